// ----- rtl/core/cmsd_pkg.sv -----
package cmsd_pkg;

    // Default geometry
    localparam int FRAMES_DEF = 8;
    localparam int ROWS_DEF   = 19;
    localparam int PLANES_DEF = 2;

    // Field and register widths
    localparam int MODE_W    = 3;
    localparam int WFRAME_W  = 3;
    localparam int WROW_W    = 5;
    localparam int DWELL_W   = 10;
    localparam int CNT_W     = 4;
    localparam int TIMEOUT_W = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;

    // Register reset values
    localparam logic [DWELL_W-1:0]   DWELL_RST   = 10'd20;
    localparam logic [CNT_W-1:0]     COUNT_RST   = 4'd8;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd10000;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = 16'hFFFF;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_BASE_DWELL   = 2'd0;
    localparam logic [1:0] REG_FRAME_COUNT  = 2'd1;
    localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FRAME  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MSEC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BUTTON = 3'd4;

    // Decoded command from the front end
    typedef enum logic [OP_W-1:0] {
        OP_NOP   = 3'd0,
        OP_WRITE = 3'd1,
        OP_SCAN  = 3'd2,
        OP_FRAME = 3'd3,
        OP_MSEC  = 3'd4,
        OP_WAKE  = 3'd5
    } t_op;

    // Configuration register set
    typedef struct packed {
        logic [DWELL_W-1:0]   base_dwell;
        logic [CNT_W-1:0]     frame_count;
        logic [TIMEOUT_W-1:0] idle_timeout;
    } t_cfg;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

// ----- rtl/core/cmsd_front.sv -----
module cmsd_front #(
    parameter int FRAMES = cmsd_pkg::FRAMES_DEF,
    parameter int ROWS   = cmsd_pkg::ROWS_DEF,
    parameter int AW     = 8
) (
    input  logic [cmsd_pkg::MODE_W-1:0]   i_mode,
    input  logic [cmsd_pkg::WFRAME_W-1:0] i_write_frame,
    input  logic [cmsd_pkg::WROW_W-1:0]   i_write_row,
    output cmsd_pkg::t_op                 o_op,
    output logic [AW-1:0]                 o_waddr
);

    logic w_in_range;

    // Writes outside the frame store are dropped here
    assign w_in_range = (int'(i_write_frame) < FRAMES) && (int'(i_write_row) < ROWS);

    // Store address of a row write
    assign o_waddr = AW'(int'(i_write_frame) * ROWS + int'(i_write_row));

    // Classify the mode
    always_comb begin
        unique case (i_mode)
            cmsd_pkg::MODE_WRITE:  o_op = w_in_range ? cmsd_pkg::OP_WRITE : cmsd_pkg::OP_NOP;
            cmsd_pkg::MODE_SCAN:   o_op = cmsd_pkg::OP_SCAN;
            cmsd_pkg::MODE_FRAME:  o_op = cmsd_pkg::OP_FRAME;
            cmsd_pkg::MODE_MSEC:   o_op = cmsd_pkg::OP_MSEC;
            cmsd_pkg::MODE_BUTTON: o_op = cmsd_pkg::OP_WAKE;
            default:               o_op = cmsd_pkg::OP_NOP;
        endcase
    end

endmodule

// ----- rtl/core/cmsd_queue.sv -----
module cmsd_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);

    localparam int DEPTH = cmsd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/cmsd_back.sv -----
module cmsd_back #(
    parameter int FRAMES = cmsd_pkg::FRAMES_DEF,
    parameter int ROWS   = cmsd_pkg::ROWS_DEF,
    parameter int PLANES = cmsd_pkg::PLANES_DEF,
    parameter int AW     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cmsd_pkg::t_cfg                i_cfg,
    input  logic                          i_cmd_valid,
    input  cmsd_pkg::t_op                 i_op,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [ROWS-2:0]               i_wbits,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ROWS-1:0]               o_pin_drive,
    output logic [ROWS-1:0]               o_pin_level,
    output logic                          o_awake,
    output logic [cmsd_pkg::WROW_W-1:0]   o_scan_row,
    output logic                          o_scan_plane,
    output logic [cmsd_pkg::WFRAME_W-1:0] o_shown_frame
);

    localparam int DEPTH = FRAMES * ROWS;
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int FPW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FLW   = (FPW + 1 > cmsd_pkg::CNT_W) ? FPW + 1 : cmsd_pkg::CNT_W;
    localparam int DW    = cmsd_pkg::DWELL_W + PLANES;
    localparam int TW    = cmsd_pkg::TIMEOUT_W;

    // Scan state
    logic [RW-1:0]  r_row;
    logic [PW-1:0]  r_plane;
    logic [DW-1:0]  r_dwell;
    logic [FPW-1:0] r_frame;
    logic [TW-1:0]  r_idle;
    logic           r_awake;

    logic [RW-1:0]  n_row;
    logic [PW-1:0]  n_plane;
    logic [DW-1:0]  n_dwell;
    logic [FPW-1:0] n_frame;
    logic [TW-1:0]  n_idle;
    logic           n_awake;

    // Frame store with per-entry written flags
    logic [ROWS-2:0]  r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [ROWS-2:0]  r_rd_data;
    logic             r_rd_ok;

    // Second stage
    logic           r_s2_valid;
    logic           r_s2_awake;
    logic [RW-1:0]  r_s2_row;
    logic [PW-1:0]  r_s2_plane;
    logic [FPW-1:0] r_s2_frame;

    // Output register
    logic                          r_out_valid;
    logic [ROWS-1:0]               r_drive;
    logic [ROWS-1:0]               r_level;
    logic                          r_out_awake;
    logic [cmsd_pkg::WROW_W-1:0]   r_out_row;
    logic                          r_out_plane;
    logic [cmsd_pkg::WFRAME_W-1:0] r_out_frame;

    logic            w_s2_adv;
    logic            w_ex_fire;
    logic            w_wr_en;
    logic            w_fwd;
    logic [AW-1:0]   w_rd_addr;
    logic [DW-1:0]   w_hold;
    logic [DW-1:0]   w_dwell_inc;
    logic [FLW-1:0]  w_limit;
    logic [FLW-1:0]  w_frame_inc;
    logic [TW-1:0]   w_idle_inc;
    logic [RW-1:0]   w_anode;
    logic [ROWS-1:0] w_anode_bit;
    logic [ROWS-2:0] w_low_mask;
    logic [ROWS-2:0] w_bits;
    logic [ROWS-1:0] w_drive;

    // Pipeline flow
    assign w_s2_adv  = !r_out_valid || !i_out_stall;
    assign w_ex_fire = i_cmd_valid && (!r_s2_valid || w_s2_adv);
    assign o_cmd_pop = w_ex_fire;
    assign w_wr_en   = w_ex_fire && (i_op == cmsd_pkg::OP_WRITE);

    // Row hold time and counter increments
    assign w_hold      = (DW'(i_cfg.base_dwell) << r_plane) + DW'(1);
    assign w_dwell_inc = r_dwell + DW'(1);
    assign w_limit     = (int'(i_cfg.frame_count) > FRAMES) ? FLW'(FRAMES)
                                                             : FLW'(i_cfg.frame_count);
    assign w_frame_inc = FLW'(r_frame) + FLW'(1);
    assign w_idle_inc  = (r_idle != cmsd_pkg::IDLE_MAX) ? r_idle + TW'(1) : r_idle;

    // Execute one command
    always_comb begin
        n_row   = r_row;
        n_plane = r_plane;
        n_dwell = r_dwell;
        n_frame = r_frame;
        n_idle  = r_idle;
        n_awake = r_awake;
        unique case (i_op)
            cmsd_pkg::OP_SCAN: begin
                if (r_awake) begin
                    if (w_dwell_inc >= w_hold) begin
                        n_dwell = '0;
                        if (r_row == RW'(ROWS - 1)) begin
                            n_row   = '0;
                            n_plane = (r_plane == PW'(PLANES - 1)) ? '0 : r_plane + 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_dwell = w_dwell_inc;
                    end
                end
            end
            cmsd_pkg::OP_FRAME: begin
                if (r_awake) begin
                    n_frame = (w_frame_inc >= w_limit) ? '0 : FPW'(w_frame_inc);
                end
            end
            cmsd_pkg::OP_MSEC: begin
                if (r_awake) begin
                    n_idle = w_idle_inc;
                    if (w_idle_inc > i_cfg.idle_timeout) begin
                        n_awake = 1'b0;
                    end
                end
            end
            cmsd_pkg::OP_WAKE: begin
                n_idle = '0;
                if (!r_awake) begin
                    n_awake = 1'b1;
                    n_row   = '0;
                    n_plane = '0;
                    n_dwell = '0;
                    n_frame = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Row to show after this command; a same-cycle write is forwarded
    assign w_rd_addr = AW'(n_frame) * AW'(ROWS) + AW'(n_row);
    assign w_fwd     = w_wr_en && (i_waddr == w_rd_addr);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_plane     <= '0;
            r_dwell     <= '0;
            r_frame     <= '0;
            r_idle      <= '0;
            r_awake     <= 1'b1;
            r_written   <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ex_fire) begin
                r_row   <= n_row;
                r_plane <= n_plane;
                r_dwell <= n_dwell;
                r_frame <= n_frame;
                r_idle  <= n_idle;
                r_awake <= n_awake;
            end
            if (w_wr_en) begin
                r_written[i_waddr] <= 1'b1;
            end
            if (w_ex_fire) begin
                r_s2_valid <= 1'b1;
            end else if (w_s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (w_s2_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Frame store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_waddr] <= i_wbits;
        end
        if (w_ex_fire) begin
            r_rd_data <= w_fwd ? i_wbits : r_mem[w_rd_addr];
            r_rd_ok   <= w_fwd || r_written[w_rd_addr];
        end
    end

    // Second stage payload
    always_ff @(posedge i_clk) begin
        if (w_ex_fire) begin
            r_s2_awake <= n_awake;
            r_s2_row   <= n_row;
            r_s2_plane <= n_plane;
            r_s2_frame <= n_frame;
        end
    end

    // Pin map: anode high, columns at or past the anode shift up one pin
    assign w_anode     = RW'(ROWS - 1) - r_s2_row;
    assign w_anode_bit = ROWS'(1) << w_anode;
    assign w_low_mask  = (ROWS - 1)'(w_anode_bit - ROWS'(1));
    assign w_bits      = r_rd_ok ? r_rd_data : '0;
    assign w_drive     = {1'b0, w_bits & w_low_mask}
                       | {w_bits & ~w_low_mask, 1'b0}
                       | w_anode_bit;

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_s2_adv && r_s2_valid) begin
            r_drive     <= r_s2_awake ? w_drive : '0;
            r_level     <= r_s2_awake ? w_anode_bit : '0;
            r_out_awake <= r_s2_awake;
            r_out_row   <= cmsd_pkg::WROW_W'(r_s2_row);
            r_out_plane <= r_s2_plane[0];
            r_out_frame <= cmsd_pkg::WFRAME_W'(r_s2_frame);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pin_drive   = r_drive;
    assign o_pin_level   = r_level;
    assign o_awake       = r_out_awake;
    assign o_scan_row    = r_out_row;
    assign o_scan_plane  = r_out_plane;
    assign o_shown_frame = r_out_frame;

endmodule

// ----- rtl/core/charlieplex_matrix_scan_driver_top.sv -----
// Path: an accepted item is written into the command queue, executed into the
// second stage with its frame store read, then registered into the output register.
// Throughput: one item per cycle while the output is not stalled, set by the execute
// stage and the one-write, one-read frame store port pair.
// Reset: synchronous, active low; the frame store reads as zero through per-entry
// written flags, so no clearing pass is needed and items are taken right after reset.
module charlieplex_matrix_scan_driver_top #(
    parameter int FRAMES = cmsd_pkg::FRAMES_DEF,
    parameter int ROWS   = cmsd_pkg::ROWS_DEF,
    parameter int PLANES = cmsd_pkg::PLANES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cmsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [cmsd_pkg::DATA_W-1:0]   pwdata,
    output logic [cmsd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cmsd_pkg::MODE_W-1:0]   i_mode,
    input  logic [cmsd_pkg::WFRAME_W-1:0] i_write_frame,
    input  logic [cmsd_pkg::WROW_W-1:0]   i_write_row,
    input  logic [ROWS-2:0]               i_write_bits,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ROWS-1:0]               o_pin_drive,
    output logic [ROWS-1:0]               o_pin_level,
    output logic                          o_awake,
    output logic [cmsd_pkg::WROW_W-1:0]   o_scan_row,
    output logic                          o_scan_plane,
    output logic [cmsd_pkg::WFRAME_W-1:0] o_shown_frame
);

    localparam int DEPTH = FRAMES * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = cmsd_pkg::OP_W + AW + ROWS - 1;

    cmsd_pkg::t_cfg  r_cfg;
    cmsd_pkg::t_op   w_front_op;
    logic [AW-1:0]   w_front_addr;
    logic            w_q_full;
    logic            w_q_valid;
    logic [QW-1:0]   w_q_data;
    logic            w_q_pop;
    logic            w_cfg_wr;
    logic [1:0]      w_cfg_idx;

    // Register access
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_dwell   <= cmsd_pkg::DWELL_RST;
            r_cfg.frame_count  <= cmsd_pkg::COUNT_RST;
            r_cfg.idle_timeout <= cmsd_pkg::TIMEOUT_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                cmsd_pkg::REG_BASE_DWELL:
                    r_cfg.base_dwell <= pwdata[cmsd_pkg::DWELL_W-1:0];
                cmsd_pkg::REG_FRAME_COUNT:
                    r_cfg.frame_count <= pwdata[cmsd_pkg::CNT_W-1:0];
                cmsd_pkg::REG_IDLE_TIMEOUT:
                    r_cfg.idle_timeout <= pwdata[cmsd_pkg::TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            cmsd_pkg::REG_BASE_DWELL:   prdata = cmsd_pkg::DATA_W'(r_cfg.base_dwell);
            cmsd_pkg::REG_FRAME_COUNT:  prdata = cmsd_pkg::DATA_W'(r_cfg.frame_count);
            cmsd_pkg::REG_IDLE_TIMEOUT: prdata = cmsd_pkg::DATA_W'(r_cfg.idle_timeout);
            default:                    prdata = '0;
        endcase
    end

    // Front end: classify the item
    cmsd_front #(
        .FRAMES (FRAMES),
        .ROWS   (ROWS),
        .AW     (AW)
    ) u_front (
        .i_mode        (i_mode),
        .i_write_frame (i_write_frame),
        .i_write_row   (i_write_row),
        .o_op          (w_front_op),
        .o_waddr       (w_front_addr)
    );

    // Command queue
    assign o_in_stall = w_q_full;

    cmsd_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  ({w_front_op, w_front_addr, i_write_bits}),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    // Back end: execute, frame store, pin map
    cmsd_back #(
        .FRAMES (FRAMES),
        .ROWS   (ROWS),
        .PLANES (PLANES),
        .AW     (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd_valid   (w_q_valid),
        .i_op          (cmsd_pkg::t_op'(w_q_data[QW-1 -: cmsd_pkg::OP_W])),
        .i_waddr       (w_q_data[ROWS-1 +: AW]),
        .i_wbits       (w_q_data[ROWS-2:0]),
        .o_cmd_pop     (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pin_drive   (o_pin_drive),
        .o_pin_level   (o_pin_level),
        .o_awake       (o_awake),
        .o_scan_row    (o_scan_row),
        .o_scan_plane  (o_scan_plane),
        .o_shown_frame (o_shown_frame)
    );

endmodule
